[rtl/rpc_pkg.sv]
// Shared types, constants and helper functions for the range pixel to
// Cartesian converter. No dependencies.
`default_nettype none
package rpc_pkg;

	localparam int MAX_ROWS_DEF    = 1024;
	localparam int MAX_COLUMNS_DEF = 1024;
	localparam int FRAC_BITS_DEF   = 8;

	localparam int AW       = 36;  // raw angle, Q30
	localparam int CW       = 34;  // CORDIC datapath
	localparam int MW       = 26;  // Q24 magnitudes
	localparam int CORDIC_N = 30;
	localparam int SQW      = 54;
	localparam int SQ_STEPS = 27;
	localparam int DW       = 27;  // root width
	localparam int PW       = 35;  // span * numerator
	localparam int OW       = 20;
	localparam int IDXW     = 3;
	localparam int CDW      = 11;

	localparam logic [IDXW-1:0] CFG_ROWS     = 3'd0;
	localparam logic [IDXW-1:0] CFG_COLUMNS  = 3'd1;
	localparam logic [IDXW-1:0] CFG_STANDOFF = 3'd2;
	localparam logic [IDXW-1:0] CFG_SCAN     = 3'd3;

	localparam logic signed [AW-1:0] AX_Q30      = 36'sd4392254;
	localparam logic signed [AW-1:0] AY_Q30      = 36'sd4389394;
	localparam logic signed [AW-1:0] AS_Q30      = 36'sd22876;
	localparam logic signed [AW-1:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [AW-1:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic [31:0]          INVK_Q30    = 32'd652032874;
	localparam logic signed [CW-1:0] ONE_Q30     = 34'sd1073741824;

	localparam longint OUT_MAX = 524287;
	localparam longint OUT_MIN = -524288;

	typedef struct packed {
		logic [9:0] row_index;
		logic [9:0] column_index;
		logic [7:0] range_value;
	} pixel_t;

	typedef struct packed {
		logic signed [OW-1:0] x_coord;
		logic signed [OW-1:0] y_coord;
		logic signed [OW-1:0] z_coord;
		logic                 is_background;
	} point_t;

	typedef struct packed {
		logic       bg;
		logic       dz;
		logic       nx;
		logic       ny;
		logic [8:0] span;
	} side_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} cord_t;

	typedef struct packed {
		logic [MW-1:0] zn;
		logic [MW-1:0] xn;
		logic [MW-1:0] t;
		side_t         side;
	} sq_pay_t;

	function automatic logic signed [CW-1:0] atan_step(input int k);
		logic signed [CW-1:0] s;
		case (k)
			0:       s = 34'sd843314857;
			1:       s = 34'sd497837829;
			2:       s = 34'sd263043837;
			3:       s = 34'sd133525159;
			4:       s = 34'sd67021687;
			5:       s = 34'sd33543516;
			6:       s = 34'sd16775851;
			7:       s = 34'sd8388437;
			8:       s = 34'sd4194283;
			9:       s = 34'sd2097149;
			10:      s = 34'sd1048576;
			default: s = 34'sd1 <<< (30 - k);
		endcase
		return s;
	endfunction

	function automatic logic signed [CW-1:0] reduce_angle(input logic signed [AW-1:0] a);
		logic signed [AW-1:0] r;
		r = a;
		for (int i = 0; i < 4; i++) begin
			if (r >= HALF_PI_Q30) r = r - PI_Q30;
		end
		for (int i = 0; i < 4; i++) begin
			if (r < -HALF_PI_Q30) r = r + PI_Q30;
		end
		return CW'(r);
	endfunction

	function automatic logic [MW-1:0] unit_mag(input logic signed [CW-1:0] v);
		logic [CW-1:0] m;
		logic [63:0]   p;
		m = v[CW-1] ? CW'(-v) : CW'(v);
		p = 64'(m[31:0]) * 64'(INVK_Q30);
		return p[36+MW-1:36];
	endfunction

endpackage
`default_nettype wire

[rtl/rpc_cordic_cell.sv]
// One CORDIC rotation step for both beam angles, registered.
// Depends on rpc_pkg.
`default_nettype none
module rpc_cordic_cell #(
	parameter int K = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          vld_i,
	input  wire rpc_pkg::side_t side_i,
	input  wire rpc_pkg::cord_t ax_i,
	input  wire rpc_pkg::cord_t ay_i,
	output logic               vld_q,
	output rpc_pkg::side_t     side_q,
	output rpc_pkg::cord_t     ax_q,
	output rpc_pkg::cord_t     ay_q
);
	localparam logic signed [rpc_pkg::CW-1:0] STEP = rpc_pkg::atan_step(K);

	function automatic rpc_pkg::cord_t rot(input rpc_pkg::cord_t c);
		rpc_pkg::cord_t o;
		if (!c.z[rpc_pkg::CW-1]) begin
			o.x = c.x - (c.y >>> K);
			o.y = c.y + (c.x >>> K);
			o.z = c.z - STEP;
		end else begin
			o.x = c.x + (c.y >>> K);
			o.y = c.y - (c.x >>> K);
			o.z = c.z + STEP;
		end
		return o;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else vld_q <= vld_i;
	end

	always_ff @(posedge clk) begin
		side_q <= side_i;
		ax_q   <= rot(ax_i);
		ay_q   <= rot(ay_i);
	end
endmodule
`default_nettype wire

[rtl/rpc_sqrt_cell.sv]
// One result bit of the integer square root, registered.
// Depends on rpc_pkg.
`default_nettype none
module rpc_sqrt_cell #(
	parameter int K = 0
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    vld_i,
	input  wire rpc_pkg::sq_pay_t        pay_i,
	input  wire logic [rpc_pkg::SQW-1:0] v_i,
	input  wire logic [rpc_pkg::SQW-1:0] r_i,
	output logic                         vld_q,
	output rpc_pkg::sq_pay_t             pay_q,
	output logic [rpc_pkg::SQW-1:0]      v_q,
	output logic [rpc_pkg::SQW-1:0]      r_q
);
	localparam logic [rpc_pkg::SQW-1:0] BIT =
		rpc_pkg::SQW'(1) << (2 * (rpc_pkg::SQ_STEPS - 1 - K));

	logic [rpc_pkg::SQW-1:0] trial;
	assign trial = r_i + BIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else vld_q <= vld_i;
	end

	always_ff @(posedge clk) begin
		pay_q <= pay_i;
		if (v_i >= trial) begin
			v_q <= v_i - trial;
			r_q <= (r_i >> 1) + BIT;
		end else begin
			v_q <= v_i;
			r_q <= r_i >> 1;
		end
	end
endmodule
`default_nettype wire

[rtl/rpc_div_cell.sv]
// One quotient bit of the three restoring dividers, registered.
// Depends on rpc_pkg.
`default_nettype none
module rpc_div_cell #(
	parameter int K  = 0,
	parameter int QB = 22,
	parameter int RW = 51
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   vld_i,
	input  wire rpc_pkg::side_t         side_i,
	input  wire logic [rpc_pkg::DW:0]   d2_i,
	input  wire logic [2:0][RW-1:0]     rem_i,
	input  wire logic [2:0][QB-1:0]     q_i,
	output logic                        vld_q,
	output rpc_pkg::side_t              side_q,
	output logic [rpc_pkg::DW:0]        d2_q,
	output logic [2:0][RW-1:0]          rem_q,
	output logic [2:0][QB-1:0]          q_q
);
	localparam int B = QB - 1 - K;
	localparam logic [QB-1:0] QBIT = QB'(1) << B;

	logic [RW-1:0] sub;
	assign sub = RW'(d2_i) << B;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else vld_q <= vld_i;
	end

	always_ff @(posedge clk) begin
		side_q <= side_i;
		d2_q   <= d2_i;
		for (int l = 0; l < 3; l++) begin
			if (rem_i[l] >= sub) begin
				rem_q[l] <= rem_i[l] - sub;
				q_q[l]   <= q_i[l] | QBIT;
			end else begin
				rem_q[l] <= rem_i[l];
				q_q[l]   <= q_i[l];
			end
		end
	end
endmodule
`default_nettype wire

[rtl/range_pixel_to_cartesian.sv]
// Range pixel to Cartesian converter, top level.
// One pixel per cycle sustained, fully pipelined through the 30-cell CORDIC,
// 27-cell root and FRAC_BITS+14-cell divider chains. busy stays low, results
// cannot be stalled.
// Reset clears the valid chain and loads the register defaults.
// Depends on rpc_pkg, rpc_cordic_cell, rpc_sqrt_cell, rpc_div_cell.
`default_nettype none
module range_pixel_to_cartesian #(
	parameter int MAX_ROWS    = rpc_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLUMNS = rpc_pkg::MAX_COLUMNS_DEF,
	parameter int FRAC_BITS   = rpc_pkg::FRAC_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire rpc_pkg::pixel_t          pixel,
	output logic                          done,
	output rpc_pkg::point_t               result,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [rpc_pkg::IDXW-1:0] cfg_index,
	input  wire logic [rpc_pkg::CDW-1:0]  cfg_data
);
	localparam int CW = rpc_pkg::CW;
	localparam int AW = rpc_pkg::AW;
	localparam int MW = rpc_pkg::MW;
	localparam int QB = 14 + FRAC_BITS;
	localparam int RW = 43 + FRAC_BITS;
	localparam int NCD = rpc_pkg::CORDIC_N;
	localparam int NSQ = rpc_pkg::SQ_STEPS;
	localparam longint BG_RAW = -200 * (longint'(1) <<< FRAC_BITS);
	localparam logic signed [rpc_pkg::OW-1:0] BG_VAL =
		(BG_RAW < rpc_pkg::OUT_MIN) ? rpc_pkg::OW'(rpc_pkg::OUT_MIN) : rpc_pkg::OW'(BG_RAW);

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// configuration
	logic [10:0] rows_q, cols_q;
	logic [7:0]  standoff_q;
	logic        scan_up_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q     <= 11'd128;
			cols_q     <= 11'd128;
			standoff_q <= 8'd10;
			scan_up_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rpc_pkg::CFG_ROWS: begin
					if (32'(cfg_data) > MAX_ROWS) rows_q <= 11'(MAX_ROWS);
					else rows_q <= cfg_data;
				end
				rpc_pkg::CFG_COLUMNS: begin
					if (32'(cfg_data) > MAX_COLUMNS) cols_q <= 11'(MAX_COLUMNS);
					else cols_q <= cfg_data;
				end
				rpc_pkg::CFG_STANDOFF: standoff_q <= cfg_data[7:0];
				rpc_pkg::CFG_SCAN:     scan_up_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// s1: angles
	logic signed [12:0] hc, hv;
	logic signed [AW-1:0] hc_w, hv_w, as_c;
	assign hc   = $signed({2'b00, pixel.column_index, 1'b1}) - $signed({2'b00, cols_q[10:1], 1'b0});
	assign hv   = $signed({2'b00, rows_q[10:1], 1'b0}) - 13'sd1
	            - $signed({2'b00, pixel.row_index, 1'b0});
	assign hc_w = AW'(hc);
	assign hv_w = AW'(hv);
	assign as_c = scan_up_q ? -rpc_pkg::AS_Q30 : rpc_pkg::AS_Q30;

	logic                 vld_s1;
	rpc_pkg::side_t       side_s1;
	logic signed [AW-1:0] ax_s1, ay_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		side_s1 <= '{bg: pixel.range_value == 8'hFF, dz: 1'b0, nx: 1'b0, ny: 1'b0,
			span: {1'b0, pixel.range_value} + {1'b0, standoff_q}};
		ax_s1   <= rpc_pkg::AX_Q30 * hc_w;
		ay_s1   <= rpc_pkg::AY_Q30 * hv_w + as_c * hc_w;
	end

	// s2: range reduction into the CORDIC chain
	logic           c_vld [NCD+1];
	rpc_pkg::side_t c_side[NCD+1];
	rpc_pkg::cord_t c_ax  [NCD+1];
	rpc_pkg::cord_t c_ay  [NCD+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) c_vld[0] <= 1'b0;
		else c_vld[0] <= vld_s1;
	end

	always_ff @(posedge clk) begin
		c_side[0] <= side_s1;
		c_ax[0]   <= '{x: rpc_pkg::ONE_Q30, y: '0, z: rpc_pkg::reduce_angle(ax_s1)};
		c_ay[0]   <= '{x: rpc_pkg::ONE_Q30, y: '0, z: rpc_pkg::reduce_angle(ay_s1)};
	end

	for (genvar k = 0; k < NCD; k++) begin : g_cordic
		rpc_cordic_cell #(.K(k)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.vld_i (c_vld[k]),
			.side_i(c_side[k]),
			.ax_i  (c_ax[k]),
			.ay_i  (c_ay[k]),
			.vld_q (c_vld[k+1]),
			.side_q(c_side[k+1]),
			.ax_q  (c_ax[k+1]),
			.ay_q  (c_ay[k+1])
		);
	end

	// s3: magnitudes
	logic           vld_s3;
	rpc_pkg::side_t side_s3;
	logic [MW-1:0]  cx_s3, sx_s3, cy_s3, sy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else vld_s3 <= c_vld[NCD];
	end

	always_ff @(posedge clk) begin
		side_s3 <= '{bg: c_side[NCD].bg, dz: c_side[NCD].dz, nx: c_ax[NCD].y[CW-1],
			ny: c_ay[NCD].y[CW-1], span: c_side[NCD].span};
		cx_s3   <= rpc_pkg::unit_mag(c_ax[NCD].x);
		sx_s3   <= rpc_pkg::unit_mag(c_ax[NCD].y);
		cy_s3   <= rpc_pkg::unit_mag(c_ay[NCD].x);
		sy_s3   <= rpc_pkg::unit_mag(c_ay[NCD].y);
	end

	// s4: projections
	logic           vld_s4;
	rpc_pkg::side_t side_s4;
	logic [MW-1:0]  t_s4, zn_s4, xn_s4, cy_s4;
	logic [2*MW-1:0] p_t, p_z, p_x;
	assign p_t = (2*MW)'(sy_s3) * (2*MW)'(cx_s3);
	assign p_z = (2*MW)'(cx_s3) * (2*MW)'(cy_s3);
	assign p_x = (2*MW)'(sx_s3) * (2*MW)'(cy_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		side_s4 <= side_s3;
		t_s4    <= p_t[24+MW-1:24];
		zn_s4   <= p_z[24+MW-1:24];
		xn_s4   <= p_x[24+MW-1:24];
		cy_s4   <= cy_s3;
	end

	// s5: squares
	logic            vld_s5;
	rpc_pkg::sq_pay_t pay_s5;
	logic [2*MW-1:0] cysq_s5, tsq_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		pay_s5  <= '{zn: zn_s4, xn: xn_s4, t: t_s4, side: side_s4};
		cysq_s5 <= (2*MW)'(cy_s4) * (2*MW)'(cy_s4);
		tsq_s5  <= (2*MW)'(t_s4) * (2*MW)'(t_s4);
	end

	// s6: sum into the root chain
	logic                    s_vld[NSQ+1];
	rpc_pkg::sq_pay_t        s_pay[NSQ+1];
	logic [rpc_pkg::SQW-1:0] s_v  [NSQ+1];
	logic [rpc_pkg::SQW-1:0] s_r  [NSQ+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) s_vld[0] <= 1'b0;
		else s_vld[0] <= vld_s5;
	end

	always_ff @(posedge clk) begin
		s_pay[0] <= pay_s5;
		s_v[0]   <= rpc_pkg::SQW'(cysq_s5) + rpc_pkg::SQW'(tsq_s5);
		s_r[0]   <= '0;
	end

	for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
		rpc_sqrt_cell #(.K(k)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.vld_i (s_vld[k]),
			.pay_i (s_pay[k]),
			.v_i   (s_v[k]),
			.r_i   (s_r[k]),
			.vld_q (s_vld[k+1]),
			.pay_q (s_pay[k+1]),
			.v_q   (s_v[k+1]),
			.r_q   (s_r[k+1])
		);
	end

	// s7: scale numerators by distance
	logic                    vld_s7;
	rpc_pkg::side_t          side_s7;
	logic [rpc_pkg::DW-1:0]  d_s7;
	logic [2:0][rpc_pkg::PW-1:0] p_s7;
	rpc_pkg::sq_pay_t        sq_o;
	assign sq_o = s_pay[NSQ];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else vld_s7 <= s_vld[NSQ];
	end

	always_ff @(posedge clk) begin
		side_s7 <= sq_o.side;
		d_s7    <= s_r[NSQ][rpc_pkg::DW-1:0];
		p_s7[0] <= rpc_pkg::PW'(sq_o.side.span) * rpc_pkg::PW'(sq_o.xn);
		p_s7[1] <= rpc_pkg::PW'(sq_o.side.span) * rpc_pkg::PW'(sq_o.t);
		p_s7[2] <= rpc_pkg::PW'(sq_o.side.span) * rpc_pkg::PW'(sq_o.zn);
	end

	// s8: dividends into the divider chain
	logic                 d_vld [QB+1];
	rpc_pkg::side_t       d_side[QB+1];
	logic [rpc_pkg::DW:0] d_d2  [QB+1];
	logic [2:0][RW-1:0]   d_rem [QB+1];
	logic [2:0][QB-1:0]   d_q   [QB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) d_vld[0] <= 1'b0;
		else d_vld[0] <= vld_s7;
	end

	always_ff @(posedge clk) begin
		d_side[0] <= '{bg: side_s7.bg, dz: d_s7 == '0, nx: side_s7.nx, ny: side_s7.ny,
			span: side_s7.span};
		d_d2[0]   <= {d_s7, 1'b0};
		d_q[0]    <= '0;
		for (int l = 0; l < 3; l++) begin
			d_rem[0][l] <= (RW'(p_s7[l]) << (FRAC_BITS + 1)) + RW'(d_s7);
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_div
		rpc_div_cell #(.K(k), .QB(QB), .RW(RW)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.vld_i (d_vld[k]),
			.side_i(d_side[k]),
			.d2_i  (d_d2[k]),
			.rem_i (d_rem[k]),
			.q_i   (d_q[k]),
			.vld_q (d_vld[k+1]),
			.side_q(d_side[k+1]),
			.d2_q  (d_d2[k+1]),
			.rem_q (d_rem[k+1]),
			.q_q   (d_q[k+1])
		);
	end

	// s9: sign, saturation, special cases
	function automatic logic signed [rpc_pkg::OW-1:0] finish(input logic [QB-1:0] q,
		input logic neg);
		logic signed [63:0] v;
		v = neg ? -$signed(64'(q)) : $signed(64'(q));
		if (v > rpc_pkg::OUT_MAX) return rpc_pkg::OW'(rpc_pkg::OUT_MAX);
		if (v < rpc_pkg::OUT_MIN) return rpc_pkg::OW'(rpc_pkg::OUT_MIN);
		return rpc_pkg::OW'(v);
	endfunction

	rpc_pkg::side_t     side_f;
	logic [2:0][QB-1:0] q_f;
	assign side_f = d_side[QB];
	assign q_f    = d_q[QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= d_vld[QB];
	end

	always_ff @(posedge clk) begin
		if (side_f.bg) begin
			result <= '{x_coord: BG_VAL, y_coord: BG_VAL, z_coord: BG_VAL,
				is_background: 1'b1};
		end else if (side_f.dz) begin
			result <= '{x_coord: '0, y_coord: '0, z_coord: '0, is_background: 1'b0};
		end else begin
			result <= '{x_coord: finish(q_f[0], side_f.nx), y_coord: finish(q_f[1], side_f.ny),
				z_coord: finish(q_f[2], 1'b0), is_background: 1'b0};
		end
	end
endmodule
`default_nettype wire

[test/tb.sv]
// Testbench for range_pixel_to_cartesian: drives pixels and register writes,
// predicts each point with a fixed-point CORDIC/root/divide model, checks done beats.
// Depends on rpc_pkg and the converter RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb;

	localparam int LATENCY   = 88;
	localparam int WDOG_MAX  = 2000;
	localparam longint AXR = 4392254, AYR = 4389394, ASR = 22876;
	localparam longint PIQ = 64'd3373259426, HPIQ = 64'd1686629713;
	localparam longint INVK = 652032874;
	localparam logic [rpc_pkg::IDXW-1:0] CFG_UNUSED = 3'd6;

	logic clk = 0, arst_n = 0, start = 0, cfg_valid = 0;
	logic busy, done, cfg_ready;
	rpc_pkg::pixel_t pixel = '0;
	rpc_pkg::point_t result;
	logic [rpc_pkg::IDXW-1:0] cfg_index = '0;
	logic [rpc_pkg::CDW-1:0] cfg_data = '0;

	range_pixel_to_cartesian dut (.clk, .arst_n, .start, .busy, .pixel, .done, .result,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data);

	initial forever #5 clk = ~clk;

	int unsigned rows_q = 128, cols_q = 128, standoff_q = 10, upward_q = 0;
	rpc_pkg::point_t pending_points[$];
	int errors = 0, n_pixels = 0, n_points = 0, n_bg = 0, idle_cycles = 0;

	function automatic longint fshr(longint v, int s);
		return v >= 0 ? (v >>> s) : (-1 - ((-1 - v) >>> s));
	endfunction

	function automatic longint mag_q24(longint v);
		longint m;
		m = v < 0 ? -v : v;
		return (m * INVK) >>> 36;
	endfunction

	function automatic void beam_trig(input longint a, output longint c, output longint s,
			output bit sneg);
		longint x, y, z, st, dx, dy;
		x = 64'd1 << 30; y = 0;
		while (a >= HPIQ) a -= PIQ;
		while (a < -HPIQ) a += PIQ;
		z = a;
		for (int i = 0; i < 30; i++) begin
			case (i)
				0: st = 843314857; 1: st = 497837829; 2: st = 263043837;
				3: st = 133525159; 4: st = 67021687; 5: st = 33543516;
				6: st = 16775851; 7: st = 8388437; 8: st = 4194283;
				9: st = 2097149; 10: st = 1048576;
				default: st = 64'd1 << (30 - i);
			endcase
			dx = fshr(y, i); dy = fshr(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= st;
			end else begin
				x += dx; y -= dy; z += st;
			end
		end
		c = mag_q24(x); s = mag_q24(y); sneg = y < 0;
	endfunction

	function automatic longint root_floor(longint unsigned v);
		longint unsigned r, b;
		r = 0; b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b; r = (r >> 1) + b;
			end else r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [rpc_pkg::OW-1:0] coord_div(longint reach, longint num, longint d,
			bit neg);
		longint unsigned n, q;
		longint v;
		n = (reach * num) << 8;
		q = (2 * n + d) / (2 * d);
		v = neg ? -longint'(q) : longint'(q);
		if (v > rpc_pkg::OUT_MAX) v = rpc_pkg::OUT_MAX;
		if (v < rpc_pkg::OUT_MIN) v = rpc_pkg::OUT_MIN;
		return v[rpc_pkg::OW-1:0];
	endfunction

	function automatic rpc_pkg::point_t project_pixel(rpc_pkg::pixel_t p);
		rpc_pkg::point_t r;
		longint hc, hv, ax, ay, cx, sx, cy, sy, t, d, reach;
		bit nx, ny;
		r = '0;
		if (p.range_value == 8'd255) begin
			r.x_coord = -20'sd51200; r.y_coord = -20'sd51200; r.z_coord = -20'sd51200;
			r.is_background = 1;
			return r;
		end
		hc = 2 * longint'(p.column_index) + 1 - 2 * longint'(cols_q >> 1);
		hv = 2 * longint'(rows_q >> 1) - 1 - 2 * longint'(p.row_index);
		ax = AXR * hc;
		ay = AYR * hv + (upward_q ? -ASR : ASR) * hc;
		beam_trig(ax, cx, sx, nx);
		beam_trig(ay, cy, sy, ny);
		t = (sy * cx) >>> 24;
		d = root_floor(cy * cy + t * t);
		reach = p.range_value + standoff_q;
		if (d != 0) begin
			r.z_coord = coord_div(reach, (cx * cy) >>> 24, d, 0);
			r.x_coord = coord_div(reach, (sx * cy) >>> 24, d, nx);
			r.y_coord = coord_div(reach, t, d, ny);
		end
		return r;
	endfunction

	// result checker and watchdog
	always @(posedge clk) begin
		rpc_pkg::point_t e;
		if (arst_n) begin
			idle_cycles <= (done || (start && !busy) || (cfg_valid && cfg_ready)) ? 0
				: idle_cycles + 1;
			if (idle_cycles > WDOG_MAX) begin
				$display("TB_ERROR");
				$finish;
			end
			if (done) begin
				n_points++;
				if (pending_points.size() == 0) begin
					$error("unexpected result beat");
					errors++;
				end else begin
					e = pending_points.pop_front();
					if (result.x_coord !== e.x_coord) begin
						$error("x_coord exp %0d got %0d", e.x_coord, result.x_coord); errors++;
					end
					if (result.y_coord !== e.y_coord) begin
						$error("y_coord exp %0d got %0d", e.y_coord, result.y_coord); errors++;
					end
					if (result.z_coord !== e.z_coord) begin
						$error("z_coord exp %0d got %0d", e.z_coord, result.z_coord); errors++;
					end
					if (result.is_background !== e.is_background) begin
						$error("is_background exp %0b got %0b", e.is_background,
							result.is_background);
						errors++;
					end
				end
			end
		end
	end

	int burst_left = 0;

	task automatic send_pixel(input rpc_pkg::pixel_t p);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 2) != 0) begin
				start <= 0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1; pixel <= p;
		do @(posedge clk); while (busy);
		pending_points.insert(pending_points.size(), project_pixel(p));
		if (p.range_value == 8'd255) n_bg++;
		n_pixels++;
	endtask

	task automatic drain;
		start <= 0;
		while (pending_points.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [rpc_pkg::IDXW-1:0] idx, input int unsigned v);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= v[rpc_pkg::CDW-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		case (idx)
			rpc_pkg::CFG_ROWS:     rows_q = (v & 11'h7FF) > 1024 ? 1024 : (v & 11'h7FF);
			rpc_pkg::CFG_COLUMNS:  cols_q = (v & 11'h7FF) > 1024 ? 1024 : (v & 11'h7FF);
			rpc_pkg::CFG_STANDOFF: standoff_q = v & 8'hFF;
			rpc_pkg::CFG_SCAN:     upward_q = v & 1;
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic rpc_pkg::pixel_t rand_pixel();
		rpc_pkg::pixel_t p;
		p.row_index = (rows_q > 0 && $urandom_range(0, 3) != 0) ?
			10'($urandom_range(0, rows_q - 1)) : 10'($urandom_range(0, 1023));
		p.column_index = (cols_q > 0 && $urandom_range(0, 3) != 0) ?
			10'($urandom_range(0, cols_q - 1)) : 10'($urandom_range(0, 1023));
		p.range_value = ($urandom_range(0, 9) == 0) ? 8'd255 : 8'($urandom_range(0, 255));
		return p;
	endfunction

	task automatic test_directed;
		send_pixel('{10'd0, 10'd0, 8'd0});
		send_pixel('{10'd1023, 10'd1023, 8'd254});
		send_pixel('{10'd63, 10'd63, 8'd100});
		send_pixel('{10'd64, 10'd64, 8'd100});
		send_pixel('{10'd0, 10'd1023, 8'd255});
		send_pixel('{10'd1023, 10'd0, 8'd1});
		send_pixel('{10'd512, 10'd300, 8'd128});
		send_pixel('{10'h2AA, 10'h155, 8'h55});
		send_pixel('{10'h155, 10'h2AA, 8'hAA});
		drain();
	endtask

	task automatic test_registers;
		// extremes: sizes 0, 1, max, above max; standoff ends; both scan directions
		int unsigned sizes[7] = '{0, 1, 2, 1024, 2047, 640, 37};
		foreach (sizes[i]) begin
			write_reg(rpc_pkg::CFG_ROWS, sizes[i]);
			write_reg(rpc_pkg::CFG_COLUMNS, sizes[(i + 3) % 7]);
			write_reg(rpc_pkg::CFG_STANDOFF, (i % 2) ? 255 : 0);
			write_reg(rpc_pkg::CFG_SCAN, i % 2);
			if (i == 2) write_reg(CFG_UNUSED, 11'h7FF);
			send_pixel('{10'd0, 10'd0, 8'd200});
			send_pixel('{10'd1023, 10'd1023, 8'd0});
			repeat (6) send_pixel(rand_pixel());
			drain();
		end
	endtask

	task automatic test_random;
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(rpc_pkg::CFG_ROWS, $urandom_range(0, 2047));
			write_reg(rpc_pkg::CFG_COLUMNS, $urandom_range(0, 2047));
			write_reg(rpc_pkg::CFG_STANDOFF, $urandom_range(0, 255));
			write_reg(rpc_pkg::CFG_SCAN, $urandom_range(0, 1));
			repeat (297) send_pixel(rand_pixel());
			drain();
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_registers();
		test_random();
		$display("Sent %0d pixels (%0d background), checked %0d points.",
			n_pixels, n_bg, n_points);
		if (errors == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire
